>>> rtl/sdv_pkg.sv
// ----------------------------------------------------------------------------
// sdv_pkg
// Shared types and constants of the snare drum voice: register map, fixed
// point constants, sequencer states and the serial ALU request/response.
// ----------------------------------------------------------------------------
package sdv_pkg;

  localparam int unsigned PHASE_BITS  = 24;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned ENV_BITS    = 24;
  localparam int unsigned OPD_BITS    = 34;   // signed ALU operand width
  localparam int unsigned DVD_BITS    = 56;   // dividend width
  localparam int unsigned MUL_STEPS   = 32;
  localparam int unsigned DIV_STEPS   = DVD_BITS;

  localparam logic [23:0] ENV_FULL      = 24'hFFFFFF;
  localparam logic [23:0] SILENCE_LEVEL = 24'd1677;
  localparam logic [23:0] SNAP_DECAY    = 24'd16759749;
  localparam logic [23:0] HP_COEF       = 24'd15921365;
  localparam logic [16:0] RATE_HZ       = 17'd48000;
  localparam logic [16:0] UNITY16       = 17'd65536;

  // quarter wave polynomial, Q30
  localparam logic [31:0] POLY_C0 = 32'd172271;
  localparam logic [31:0] POLY_C1 = 32'd5027000;
  localparam logic [31:0] POLY_C2 = 32'd85569306;
  localparam logic [31:0] POLY_C3 = 32'd693598669;
  localparam logic [31:0] POLY_C4 = 32'd1686629713;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;

  // soft clip, Q5.24
  localparam logic [28:0] CLIP_LIMIT = 29'd50331648;   // 3.0
  localparam logic [28:0] CLIP_K27   = 29'd452984832;  // 27.0

  typedef enum logic [2:0] {
    REG_PITCH  = 3'd0,
    REG_TUNE   = 3'd1,
    REG_BUMP   = 3'd2,
    REG_DECAY  = 3'd3,
    REG_SNAP   = 3'd4,
    REG_NOISE  = 3'd5,
    REG_TONE   = 3'd6,
    REG_DRIVE  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [8:0]  pitch_hz;
    logic [8:0]  tune_hz;
    logic [16:0] bump_level;
    logic [23:0] amp_decay_factor;
    logic [16:0] snap_level;
    logic [16:0] noise_level;
    logic [16:0] tone_balance;
    logic [16:0] clip_drive;
  } cfg_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic                        start;
    alu_op_e                     op;
    logic signed [OPD_BITS-1:0]  a;
    logic signed [OPD_BITS-1:0]  b;
    logic [DVD_BITS-1:0]         dvd;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_AMP, S_SNAPENV, S_INC1, S_INC2, S_WSETUP, S_SQ,
    S_P1, S_P2, S_P3, S_P4, S_SV, S_MIX1, S_MIX2, S_MIXENV, S_SNAP1,
    S_SNAP2, S_HP, S_BODY1, S_BODY2, S_DRV, S_CSQ, S_NUM, S_DIV, S_OUT
  } state_e;

  // gains above unity are taken as unity
  function automatic logic [16:0] gain16(input logic [16:0] g);
    gain16 = (g > UNITY16) ? UNITY16 : g;
  endfunction

endpackage

>>> rtl/sdv_serial_alu.sv
// ----------------------------------------------------------------------------
// sdv_serial_alu
// Bit-serial multiplier (shift-add, 32 steps) and restoring divider
// (56 steps) sharing one accumulator shift register.
// ----------------------------------------------------------------------------
module sdv_serial_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdv_pkg::alu_req_t req_i,
  output sdv_pkg::alu_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [5:0]       cnt_q, cnt_d;
  sdv_pkg::alu_op_e op_q, op_d;
  logic             neg_q, neg_d;
  logic [31:0]      mcand_q, mcand_d;
  logic [63:0]      acc_q, acc_d;
  logic [31:0]      rem_q, rem_d;

  logic [sdv_pkg::OPD_BITS-1:0] mag_a, mag_b;
  logic [32:0] mul_sum, trial;
  logic        ge;
  logic        last;

  assign mag_a   = req_i.a[sdv_pkg::OPD_BITS-1] ? -req_i.a : req_i.a;
  assign mag_b   = req_i.b[sdv_pkg::OPD_BITS-1] ? -req_i.b : req_i.b;
  assign mul_sum = {1'b0, acc_q[63:32]} + (acc_q[0] ? {1'b0, mcand_q} : 33'd0);
  assign trial   = {rem_q, acc_q[sdv_pkg::DVD_BITS-1]};
  assign ge      = trial >= {1'b0, mcand_q};
  assign last    = (op_q == sdv_pkg::ALU_MUL) ?
                   (cnt_q == 6'(sdv_pkg::MUL_STEPS - 1)) :
                   (cnt_q == 6'(sdv_pkg::DIV_STEPS - 1));

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    op_d    = op_q;
    neg_d   = neg_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = req_i.op;
      rem_d  = '0;
      if (req_i.op == sdv_pkg::ALU_MUL) begin
        neg_d   = req_i.a[sdv_pkg::OPD_BITS-1] ^ req_i.b[sdv_pkg::OPD_BITS-1];
        mcand_d = mag_a[31:0];
        acc_d   = {32'd0, mag_b[31:0]};
      end else begin
        neg_d   = 1'b0;
        mcand_d = mag_b[31:0];
        acc_d   = 64'(req_i.dvd);
      end
    end else if (busy_q) begin
      cnt_d = cnt_q + 6'd1;
      if (op_q == sdv_pkg::ALU_MUL) begin
        acc_d = {mul_sum, acc_q[31:1]};
      end else begin
        rem_d = ge ? 32'(trial - {1'b0, mcand_q}) : trial[31:0];
        acc_d = {acc_q[63:sdv_pkg::DVD_BITS], acc_q[sdv_pkg::DVD_BITS-2:0], ge};
      end
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= sdv_pkg::ALU_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

>>> rtl/sdv_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdv_cfg_regs
// APB register bank holding the voice settings.
// ----------------------------------------------------------------------------
module sdv_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output sdv_pkg::cfg_t cfg_o
);

  sdv_pkg::cfg_t     cfg_q, cfg_d;
  sdv_pkg::reg_idx_e idx;
  logic              wr;

  assign idx    = sdv_pkg::reg_idx_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        sdv_pkg::REG_PITCH: cfg_d.pitch_hz         = pwdata[8:0];
        sdv_pkg::REG_TUNE:  cfg_d.tune_hz          = pwdata[8:0];
        sdv_pkg::REG_BUMP:  cfg_d.bump_level       = pwdata[16:0];
        sdv_pkg::REG_DECAY: cfg_d.amp_decay_factor = pwdata[23:0];
        sdv_pkg::REG_SNAP:  cfg_d.snap_level       = pwdata[16:0];
        sdv_pkg::REG_NOISE: cfg_d.noise_level      = pwdata[16:0];
        sdv_pkg::REG_TONE:  cfg_d.tone_balance     = pwdata[16:0];
        sdv_pkg::REG_DRIVE: cfg_d.clip_drive       = pwdata[16:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sdv_pkg::REG_PITCH: prdata = 32'(cfg_q.pitch_hz);
      sdv_pkg::REG_TUNE:  prdata = 32'(cfg_q.tune_hz);
      sdv_pkg::REG_BUMP:  prdata = 32'(cfg_q.bump_level);
      sdv_pkg::REG_DECAY: prdata = 32'(cfg_q.amp_decay_factor);
      sdv_pkg::REG_SNAP:  prdata = 32'(cfg_q.snap_level);
      sdv_pkg::REG_NOISE: prdata = 32'(cfg_q.noise_level);
      sdv_pkg::REG_TONE:  prdata = 32'(cfg_q.tone_balance);
      sdv_pkg::REG_DRIVE: prdata = 32'(cfg_q.clip_drive);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch_hz         <= 9'd180;
      cfg_q.tune_hz          <= 9'd100;
      cfg_q.bump_level       <= 17'd0;
      cfg_q.amp_decay_factor <= 24'd16776000;
      cfg_q.snap_level       <= 17'd32768;
      cfg_q.noise_level      <= 17'd32768;
      cfg_q.tone_balance     <= 17'd32768;
      cfg_q.clip_drive       <= 17'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/sdv_voice_seq.sv
// ----------------------------------------------------------------------------
// sdv_voice_seq
// Sequencer and voice state: steps one sample through the serial ALU and
// holds the finished sample in the output register.
// ----------------------------------------------------------------------------
module sdv_voice_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdv_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               trigger_i,
  input  logic signed [15:0] snap_noise_i,
  input  logic signed [15:0] body_noise_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic               sounding_o,
  output sdv_pkg::alu_req_t  alu_req_o,
  input  sdv_pkg::alu_rsp_t  alu_rsp_i
);

  sdv_pkg::state_e state_q, state_d;
  logic            issued_q, issued_d;

  // voice state
  logic [23:0]        amp_env_q, snap_env_q, ph1_q, ph2_q;
  logic signed [15:0] hp_in_q, hp_out_q;
  // output register
  logic               out_valid_q;
  logic signed [15:0] sample_q;
  logic               sounding_q;
  // working registers
  logic signed [15:0] snapn_q, bodyn_q, o1_q, o2_q, fin_q;
  logic               fin_snd_q, pass_q, neg_q;
  logic [1:0]         quad_q;
  logic [30:0]        x_q, x2_q;
  logic [31:0]        p_q;
  logic signed [32:0] t1_q;
  logic signed [16:0] mix_q, snap_q;
  logic signed [18:0] sum_q;
  logic [55:0]        num_q;

  logic accept, load, op_st;
  logic signed [63:0] res;
  logic [16:0] g_bump, g_snap, g_noise, g_tone, g_drive;
  logic [25:0] f1;
  logic [9:0]  f2;
  logic [23:0] ph_sel;
  logic [29:0] x_raw;
  logic [30:0] x_wave;
  logic [31:0] coef;
  logic [34:0] s_sum;
  logic [19:0] s_rnd;
  logic signed [15:0] sine_val;
  logic signed [33:0] mix_sum;
  logic signed [17:0] hp_v;
  logic signed [15:0] hp_sat;
  logic signed [16:0] body_new;
  logic signed [18:0] sum_new;
  logic signed [15:0] sum_sat;
  logic signed [20:0] drv_v;
  logic [19:0] drv_mag;
  logic [28:0] clip_x;
  logic        clip_big;
  logic [15:0] clip_r;
  logic [31:0] clip_den;

  assign res     = alu_rsp_i.res;
  assign accept  = in_valid_i && in_ready_o;
  assign load    = (state_q == sdv_pkg::S_OUT) && (!out_valid_q || out_ready_i);
  assign g_bump  = sdv_pkg::gain16(cfg_i.bump_level);
  assign g_snap  = sdv_pkg::gain16(cfg_i.snap_level);
  assign g_noise = sdv_pkg::gain16(cfg_i.noise_level);
  assign g_tone  = sdv_pkg::gain16(cfg_i.tone_balance);
  assign g_drive = sdv_pkg::gain16(cfg_i.clip_drive);
  // bump adds up to 80 Hz: g*80 = g*64 + g*16
  assign f1      = {cfg_i.pitch_hz, 16'd0} + 26'({g_bump, 6'd0}) + 26'({g_bump, 4'd0});
  assign f2      = 10'(cfg_i.pitch_hz) + 10'(cfg_i.tune_hz);

  // quarter wave folding of the quantised phase
  assign ph_sel  = pass_q ? ph2_q : ph1_q;
  assign x_raw   = {ph_sel[21:14], 22'd0};
  assign x_wave  = ph_sel[22] ? (sdv_pkg::Q30_ONE - {1'b0, x_raw}) : {1'b0, x_raw};

  always_comb begin
    unique case (state_q)
      sdv_pkg::S_P1: coef = sdv_pkg::POLY_C1;
      sdv_pkg::S_P2: coef = sdv_pkg::POLY_C2;
      sdv_pkg::S_P3: coef = sdv_pkg::POLY_C3;
      default:       coef = sdv_pkg::POLY_C4;
    endcase
  end

  // sine rounding and clamp
  assign s_sum    = {1'b0, res[63:30]} + 35'd16384;
  assign s_rnd    = s_sum[34:15];
  assign sine_val = quad_q[1] ?
                    -$signed({1'b0, ((s_rnd > 20'd32767) ? 15'h7FFF : s_rnd[14:0])}) :
                    $signed({1'b0, ((s_rnd > 20'd32767) ? 15'h7FFF : s_rnd[14:0])});

  assign mix_sum  = 34'(t1_q) + res[33:0];
  assign hp_v     = res[41:24];
  assign hp_sat   = (hp_v > 18'sd32767) ? 16'sh7FFF :
                    (hp_v < -18'sd32768) ? -16'sh8000 : hp_v[15:0];
  assign body_new = res[40:24];
  assign sum_new  = 19'(mix_q) + 19'(snap_q) + 19'(body_new);
  assign sum_sat  = (sum_new > 19'sd32767) ? 16'sh7FFF :
                    (sum_new < -19'sd32768) ? -16'sh8000 : sum_new[15:0];
  assign drv_v    = res[36:16];
  assign drv_mag  = drv_v[20] ? 20'(-drv_v) : drv_v[19:0];
  assign clip_x   = {drv_mag, 9'd0};
  assign clip_big = clip_x >= sdv_pkg::CLIP_LIMIT;
  assign clip_r   = (|res[55:24]) ? 16'd32767 : {1'b0, res[23:9]};
  assign clip_den = 32'(sdv_pkg::CLIP_K27) + 32'({x2_q, 3'd0}) + 32'(x2_q);

  // next state and ALU requests
  always_comb begin
    state_d       = state_q;
    issued_d      = issued_q;
    op_st         = 1'b0;
    alu_req_o     = '0;
    alu_req_o.op  = sdv_pkg::ALU_MUL;
    unique case (state_q)
      sdv_pkg::S_IDLE: begin
        if (in_valid_i) state_d = sdv_pkg::S_CHECK;
      end
      sdv_pkg::S_CHECK: begin
        state_d = (amp_env_q <= sdv_pkg::SILENCE_LEVEL) ? sdv_pkg::S_OUT : sdv_pkg::S_AMP;
      end
      sdv_pkg::S_AMP: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(amp_env_q);
        alu_req_o.b = 34'(cfg_i.amp_decay_factor);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_SNAPENV;
      end
      sdv_pkg::S_SNAPENV: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(snap_env_q);
        alu_req_o.b = 34'(sdv_pkg::SNAP_DECAY);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_INC1;
      end
      sdv_pkg::S_INC1: begin
        op_st = 1'b1;
        alu_req_o.op  = sdv_pkg::ALU_DIV;
        alu_req_o.dvd = 56'({f1, 8'd0});
        alu_req_o.b   = 34'(sdv_pkg::RATE_HZ);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_INC2;
      end
      sdv_pkg::S_INC2: begin
        op_st = 1'b1;
        alu_req_o.op  = sdv_pkg::ALU_DIV;
        alu_req_o.dvd = 56'({f2, 24'd0});
        alu_req_o.b   = 34'(sdv_pkg::RATE_HZ);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_WSETUP;
      end
      sdv_pkg::S_WSETUP: state_d = sdv_pkg::S_SQ;
      sdv_pkg::S_SQ: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(x_q);
        alu_req_o.b = 34'(x_q);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_P1;
      end
      sdv_pkg::S_P1: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(sdv_pkg::POLY_C0);
        alu_req_o.b = 34'(x2_q);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_P2;
      end
      sdv_pkg::S_P2, sdv_pkg::S_P3, sdv_pkg::S_P4: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(p_q);
        alu_req_o.b = 34'(x2_q);
        if (alu_rsp_i.done) begin
          state_d = (state_q == sdv_pkg::S_P2) ? sdv_pkg::S_P3 :
                    (state_q == sdv_pkg::S_P3) ? sdv_pkg::S_P4 : sdv_pkg::S_SV;
        end
      end
      sdv_pkg::S_SV: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(p_q);
        alu_req_o.b = 34'(x_q);
        if (alu_rsp_i.done) state_d = pass_q ? sdv_pkg::S_MIX1 : sdv_pkg::S_WSETUP;
      end
      sdv_pkg::S_MIX1: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(o1_q);
        alu_req_o.b = 34'(g_tone);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_MIX2;
      end
      sdv_pkg::S_MIX2: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(o2_q);
        alu_req_o.b = 34'(sdv_pkg::UNITY16 - g_tone);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_MIXENV;
      end
      sdv_pkg::S_MIXENV: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(mix_q);
        alu_req_o.b = 34'(amp_env_q);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_SNAP1;
      end
      sdv_pkg::S_SNAP1: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(snapn_q);
        alu_req_o.b = 34'(g_snap);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_SNAP2;
      end
      sdv_pkg::S_SNAP2: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(snap_q);
        alu_req_o.b = 34'(snap_env_q);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_HP;
      end
      sdv_pkg::S_HP: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(hp_out_q) + 34'(bodyn_q) - 34'(hp_in_q);
        alu_req_o.b = 34'(sdv_pkg::HP_COEF);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_BODY1;
      end
      sdv_pkg::S_BODY1: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(hp_out_q);
        alu_req_o.b = 34'(g_noise);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_BODY2;
      end
      sdv_pkg::S_BODY2: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(t1_q);   // filtered noise times gain, from BODY1
        alu_req_o.b = 34'(amp_env_q);
        if (alu_rsp_i.done) state_d = (g_drive == 17'd0) ? sdv_pkg::S_OUT : sdv_pkg::S_DRV;
      end
      sdv_pkg::S_DRV: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(sum_q);
        alu_req_o.b = 34'(19'(sdv_pkg::UNITY16) + 19'({g_drive, 2'd0}) + 19'(g_drive));
        if (alu_rsp_i.done) state_d = clip_big ? sdv_pkg::S_OUT : sdv_pkg::S_CSQ;
      end
      sdv_pkg::S_CSQ: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(x_q);
        alu_req_o.b = 34'(x_q);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_NUM;
      end
      sdv_pkg::S_NUM: begin
        op_st = 1'b1;
        alu_req_o.a = 34'(x_q);
        alu_req_o.b = 34'(sdv_pkg::CLIP_K27) + 34'(x2_q);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_DIV;
      end
      sdv_pkg::S_DIV: begin
        op_st = 1'b1;
        alu_req_o.op  = sdv_pkg::ALU_DIV;
        alu_req_o.dvd = num_q;
        alu_req_o.b   = 34'(clip_den);
        if (alu_rsp_i.done) state_d = sdv_pkg::S_OUT;
      end
      sdv_pkg::S_OUT: begin
        if (load) state_d = sdv_pkg::S_IDLE;
      end
      default: state_d = sdv_pkg::S_IDLE;
    endcase
    if (op_st) begin
      alu_req_o.start = !issued_q;
      if (!issued_q) issued_d = 1'b1;
      if (alu_rsp_i.done) issued_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdv_pkg::S_IDLE;
      issued_q    <= 1'b0;
      amp_env_q   <= '0;
      snap_env_q  <= '0;
      ph1_q       <= '0;
      ph2_q       <= '0;
      hp_in_q     <= '0;
      hp_out_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (accept && trigger_i) begin
        amp_env_q  <= sdv_pkg::ENV_FULL;
        snap_env_q <= sdv_pkg::ENV_FULL;
        ph1_q      <= '0;
        ph2_q      <= '0;
      end
      if (alu_rsp_i.done) begin
        unique case (state_q)
          sdv_pkg::S_AMP:     amp_env_q  <= res[47:24];
          sdv_pkg::S_SNAPENV: snap_env_q <= res[47:24];
          sdv_pkg::S_INC1:    ph1_q      <= ph1_q + res[23:0];
          sdv_pkg::S_INC2:    ph2_q      <= ph2_q + res[23:0];
          sdv_pkg::S_HP: begin
            hp_in_q  <= bodyn_q;
            hp_out_q <= hp_sat;
          end
          default: ;
        endcase
      end
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      snapn_q <= snap_noise_i;
      bodyn_q <= body_noise_i;
    end
    if (state_q == sdv_pkg::S_CHECK) begin
      fin_q     <= '0;
      fin_snd_q <= 1'b0;
    end
    if (state_q == sdv_pkg::S_WSETUP) begin
      x_q    <= x_wave;
      quad_q <= ph_sel[23:22];
    end
    if (load) begin
      sample_q   <= fin_q;
      sounding_q <= fin_snd_q;
    end
    if (alu_rsp_i.done) begin
      unique case (state_q)
        sdv_pkg::S_INC2: pass_q <= 1'b0;
        sdv_pkg::S_SQ:   x2_q   <= res[60:30];
        sdv_pkg::S_P1:   p_q    <= coef - res[61:30];
        sdv_pkg::S_P2, sdv_pkg::S_P3, sdv_pkg::S_P4: p_q <= coef - res[61:30];
        sdv_pkg::S_SV: begin
          if (pass_q) o2_q <= sine_val;
          else        o1_q <= sine_val;
          pass_q <= 1'b1;
        end
        sdv_pkg::S_MIX1:   t1_q  <= res[32:0];
        sdv_pkg::S_MIX2:   mix_q <= mix_sum[32:16];
        sdv_pkg::S_MIXENV: mix_q <= res[40:24];
        sdv_pkg::S_SNAP1:  snap_q <= res[32:16];
        sdv_pkg::S_SNAP2:  snap_q <= res[40:24];
        sdv_pkg::S_BODY1:  t1_q   <= 33'($signed(res[32:16]));
        sdv_pkg::S_BODY2: begin
          sum_q     <= sum_new;
          fin_q     <= sum_sat;
          fin_snd_q <= 1'b1;
        end
        sdv_pkg::S_DRV: begin
          neg_q <= drv_v[20];
          x_q   <= 31'(clip_x);
          if (clip_big) fin_q <= drv_v[20] ? -16'sd32767 : 16'sd32767;
        end
        sdv_pkg::S_CSQ: x2_q  <= res[54:24];
        sdv_pkg::S_NUM: num_q <= res[55:0];
        sdv_pkg::S_DIV: fin_q <= neg_q ? -$signed(clip_r) : $signed(clip_r);
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == sdv_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign sounding_o  = sounding_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("item accepted while another is in work");

  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp_i.done |-> issued_q)
    else $error("ALU result without a request");

  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sounding_o) |-> (sample_o == 16'sd0))
    else $error("silent item carries a non-zero sample");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdv_pkg::S_OUT && out_valid_q && !out_ready_i) |=>
    (state_q == sdv_pkg::S_OUT))
    else $error("result lost while output stalled");

endmodule

>>> rtl/snare_drum_voice_core.sv
// ----------------------------------------------------------------------------
// snare_drum_voice_core
// Snare drum synthesis voice: two sine oscillators, snap burst and
// high-passed noise, optional soft clip, one Q1.15 sample per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one item per 48 kHz tick:
//   trigger_i, snap_noise_i and body_noise_i. A trigger restarts the hit
//   before the tick is processed.
//   Output channel (out_valid_o/out_ready_i) returns one item per input
//   item: sample_o (Q1.15, saturated) and sounding_o.
//   One item is worked on at a time. A silent tick reaches the output
//   register without ALU work. A sounding tick runs on the single
//   bit-serial ALU (multiply 32 steps, divide 56, each plus a hand-off):
//   22 to 25 multiplies and 2 to 3 divides, more with a saturating drive
//   and most with the soft clip working.
//   Settings are written over the APB port (registers at 4*i) while
//   idle; this binds the user, the block itself does not enforce it.
//   Reset loads the default settings, clears both envelopes, phases and
//   the high-pass history; the voice is then silent until triggered.
//   A stalled receiver holds the finished item in the output register; the
//   next item may be accepted meanwhile but waits before being delivered.
// ----------------------------------------------------------------------------
module snare_drum_voice_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB settings port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // tick items in
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               trigger_i,
  input  logic signed [15:0] snap_noise_i,
  input  logic signed [15:0] body_noise_i,
  // sample items out
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic               sounding_o
);

  sdv_pkg::cfg_t     cfg;
  sdv_pkg::alu_req_t alu_req;
  sdv_pkg::alu_rsp_t alu_rsp;

  // settings bank
  sdv_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: envelopes, phases, sine polynomial, mix, filter, clip
  sdv_voice_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .trigger_i    (trigger_i),
    .snap_noise_i (snap_noise_i),
    .body_noise_i (body_noise_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_o     (sample_o),
    .sounding_o   (sounding_o),
    .alu_req_o    (alu_req),
    .alu_rsp_i    (alu_rsp)
  );

  // shared one-bit-per-cycle multiply/divide unit
  sdv_serial_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

endmodule
